// ----- src/c2p_pkg.sv -----
// ----------------------------------------------------------------------------
// c2p_pkg
// Shared types and codes of the sprite chunky-to-planar packer.
// ----------------------------------------------------------------------------
`default_nettype none

package c2p_pkg;

   // transaction commands
   localparam logic [1:0] CMD_PIXEL = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_PLANE   = 2'd0;
   localparam logic [1:0] KIND_PALETTE = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // error codes
   localparam logic [1:0] ERR_NONE        = 2'd0;
   localparam logic [1:0] ERR_TOO_MANY    = 2'd1;
   localparam logic [1:0] ERR_NEED_ATTACH = 2'd2;

   // register indexes
   localparam logic [1:0] REG_ROW_WIDTH   = 2'd0;
   localparam logic [1:0] REG_ATTACH_MODE = 2'd1;
   localparam logic [1:0] REG_INDEX_INPUT = 2'd2;

   localparam logic [7:0] ROW_WIDTH_RESET = 8'd16;
   localparam int         ATTACH_LIMIT    = 64;
   localparam int         PLANES          = 4;
   localparam int         GROUP_PIXELS    = 16;

   // job queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [7:0] row_width;
      logic       attach_mode;
      logic       index_input;
   } cfg_type;

   // one queued job: a palette read, or a pixel with an error and/or a closed group
   typedef struct packed {
      logic                               is_pal;
      logic [15:0]                        pal_word;
      logic [1:0]                         err;
      logic                               close;
      logic                               four;
      logic [4:0]                         count;
      logic [PLANES-1:0][GROUP_PIXELS-1:0] words;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

`default_nettype wire

// ----- src/c2p_if.sv -----
// ----------------------------------------------------------------------------
// c2p channel interfaces
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface c2p_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [23:0] pixel_color;
   logic [3:0]  pixel_index;
   logic [3:0]  entry_number;

   modport source (output valid, command, pixel_color, pixel_index, entry_number,
                   input ready);
   modport sink   (input valid, command, pixel_color, pixel_index, entry_number,
                   output ready);
endinterface

interface c2p_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] data_word;
   logic [1:0]  plane_number;
   logic        group_last;
   logic [4:0]  color_count;
   logic [1:0]  error_code;

   modport source (output valid, kind, data_word, plane_number, group_last,
                   color_count, error_code, input ready);
   modport sink   (input valid, kind, data_word, plane_number, group_last,
                   color_count, error_code, output ready);
endinterface

interface c2p_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- src/c2p_front.sv -----
// ----------------------------------------------------------------------------
// c2p_front
// Accepts transactions, matches and learns colors, shifts the plane registers
// and hands jobs with results to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module c2p_front #(
   parameter int PALETTE_ENTRIES = 16,
   parameter int MAX_ROW_WIDTH   = 128
) (
   input  wire logic           clock,
   input  wire logic           reset,
   c2p_req_if.sink             req_chan,
   input  wire c2p_pkg::cfg_type      cfg,
   input  wire c2p_pkg::q_status_type q_status,
   output logic                push,
   output c2p_pkg::job_type    push_job
);

   localparam int          IW      = $clog2(PALETTE_ENTRIES);
   localparam int          LIM     = (MAX_ROW_WIDTH < c2p_pkg::ATTACH_LIMIT) ?
                                     MAX_ROW_WIDTH : c2p_pkg::ATTACH_LIMIT;
   localparam logic [7:0]  LIM_MAX = 8'(MAX_ROW_WIDTH);
   localparam logic [7:0]  LIM_ATT = 8'(LIM);
   localparam logic [4:0]  ENTRIES = 5'(PALETTE_ENTRIES);

   logic [23:0] color_tbl_ff [PALETTE_ENTRIES];
   logic [4:0]  learned_ff, learned_in;
   logic [c2p_pkg::PLANES-1:0][15:0] shift_ff, shift_in;
   logic [6:0]  row_pos_ff, row_pos_in;

   logic        accept;
   logic        hit;
   logic [3:0]  match_idx;
   logic [3:0]  idx;
   logic [1:0]  err;
   logic        learn;
   logic [7:0]  lim;
   logic [7:0]  width_eff;
   logic [7:0]  pos;
   logic        row_end;
   logic        close;
   logic [3:0]  pad;
   logic [c2p_pkg::PLANES-1:0][15:0] shifted;
   logic [c2p_pkg::PLANES-1:0][15:0] padded;
   logic [23:0] pal_color;
   logic [15:0] pal_word;

   assign req_chan.ready = !q_status.full;
   assign accept         = req_chan.valid && req_chan.ready;

   // parallel color match, lowest entry wins
   always_comb begin
      hit       = 1'b0;
      match_idx = '0;
      for (int i = PALETTE_ENTRIES - 1; i >= 0; i--) begin
         if ((5'(i) < learned_ff) && (color_tbl_ff[i] == req_chan.pixel_color)) begin
            hit       = 1'b1;
            match_idx = 4'(i);
         end
      end
   end

   // pixel index and error classification
   always_comb begin
      idx   = '0;
      err   = c2p_pkg::ERR_NONE;
      learn = 1'b0;
      if (cfg.index_input) begin
         idx = req_chan.pixel_index;
      end else if (hit) begin
         idx = match_idx;
      end else if (learned_ff < ENTRIES) begin
         idx   = learned_ff[3:0];
         learn = 1'b1;
      end else begin
         err = c2p_pkg::ERR_TOO_MANY;
      end
      if ((err == c2p_pkg::ERR_NONE) && (idx[3:2] != 2'b00) && !cfg.attach_mode) begin
         err = c2p_pkg::ERR_NEED_ATTACH;
      end
   end

   // effective row width
   always_comb begin
      lim       = cfg.attach_mode ? LIM_ATT : LIM_MAX;
      width_eff = cfg.row_width;
      if (width_eff == 8'd0) begin
         width_eff = 8'd1;
      end
      if (width_eff > lim) begin
         width_eff = lim;
      end
   end

   // row position and group closing
   assign pos     = {1'b0, row_pos_ff} + 8'd1;
   assign row_end = pos >= width_eff;
   assign close   = row_end || (row_pos_ff[3:0] == 4'hf);
   assign pad     = 4'hf - row_pos_ff[3:0];

   // plane shift and left alignment of a short group
   always_comb begin
      for (int p = 0; p < c2p_pkg::PLANES; p++) begin
         shifted[p] = {shift_ff[p][14:0], idx[p]};
         padded[p]  = shifted[p] << pad;
      end
   end

   // palette read in the 12-bit word format
   always_comb begin
      pal_color = color_tbl_ff[req_chan.entry_number[IW-1:0]];
      pal_word  = '0;
      if ((5'(req_chan.entry_number) < learned_ff) &&
          (5'(req_chan.entry_number) < ENTRIES)) begin
         pal_word = {pal_color[15:12], pal_color[7:4], 4'h0, pal_color[23:20]};
      end
   end

   // next state
   always_comb begin
      learned_in = learned_ff;
      shift_in   = shift_ff;
      row_pos_in = row_pos_ff;
      if (accept) begin
         case (req_chan.command)
            c2p_pkg::CMD_CLEAR: begin
               learned_in = '0;
               shift_in   = '0;
               row_pos_in = '0;
            end
            c2p_pkg::CMD_PIXEL: begin
               if (learn) begin
                  learned_in = learned_ff + 5'd1;
               end
               shift_in   = close ? '0 : shifted;
               row_pos_in = row_end ? 7'd0 : pos[6:0];
            end
            default: begin
            end
         endcase
      end
   end

   // job for the back end
   always_comb begin
      push              = 1'b0;
      push_job.is_pal   = 1'b0;
      push_job.pal_word = pal_word;
      push_job.err      = err;
      push_job.close    = close;
      push_job.four     = cfg.attach_mode;
      push_job.count    = learned_in;
      push_job.words    = padded;
      if (accept) begin
         case (req_chan.command)
            c2p_pkg::CMD_READ: begin
               push            = 1'b1;
               push_job.is_pal = 1'b1;
            end
            c2p_pkg::CMD_PIXEL: begin
               push = close || (err != c2p_pkg::ERR_NONE);
            end
            default: begin
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         learned_ff <= '0;
         shift_ff   <= '0;
         row_pos_ff <= '0;
      end else begin
         learned_ff <= learned_in;
         shift_ff   <= shift_in;
         row_pos_ff <= row_pos_in;
      end
   end

   // color table, written on append only
   always_ff @(posedge clock) begin
      if (accept && (req_chan.command == c2p_pkg::CMD_PIXEL) && learn) begin
         color_tbl_ff[learned_ff[IW-1:0]] <= req_chan.pixel_color;
      end
   end

endmodule

`default_nettype wire

// ----- src/c2p_queue.sv -----
// ----------------------------------------------------------------------------
// c2p_queue
// Short job queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module c2p_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire c2p_pkg::job_type push_job,
   input  wire logic             pop,
   output c2p_pkg::job_type      head_job,
   output c2p_pkg::q_status_type q_status
);

   localparam logic [c2p_pkg::QPTR_W:0] DEPTH = (c2p_pkg::QPTR_W + 1)'(c2p_pkg::QUEUE_DEPTH);

   c2p_pkg::job_type             entry_ff [c2p_pkg::QUEUE_DEPTH];
   logic [c2p_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [c2p_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [c2p_pkg::QPTR_W:0]     count_ff, count_in;

   assign q_status.full  = count_ff == DEPTH;
   assign q_status.empty = count_ff == '0;
   assign head_job       = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ----- src/c2p_back.sv -----
// ----------------------------------------------------------------------------
// c2p_back
// Expands each queued job into its result transactions, one per cycle while
// the response channel is ready, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module c2p_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire c2p_pkg::job_type      head_job,
   input  wire c2p_pkg::q_status_type q_status,
   output logic                       pop,
   c2p_rsp_if.source                  rsp_chan
);

   logic [2:0]  step_ff, step_in;
   logic        valid_ff, valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [15:0] data_ff, data_in;
   logic [1:0]  plane_ff, plane_in;
   logic        last_ff, last_in;
   logic [4:0]  count_ff, count_in;
   logic [1:0]  err_ff, err_in;

   logic        load;
   logic        has_err;
   logic        final_res;
   logic [1:0]  plane;
   logic [1:0]  top_plane;

   assign load    = !q_status.empty && (!valid_ff || rsp_chan.ready);
   assign has_err = head_job.err != c2p_pkg::ERR_NONE;
   assign plane   = has_err ? 2'(step_ff - 3'd1) : step_ff[1:0];
   assign top_plane = head_job.four ? 2'd3 : 2'd1;

   // result for the current step of the head job
   always_comb begin
      kind_in   = c2p_pkg::KIND_PLANE;
      data_in   = head_job.words[plane];
      plane_in  = plane;
      last_in   = plane == top_plane;
      err_in    = c2p_pkg::ERR_NONE;
      final_res = plane == top_plane;
      count_in  = head_job.count;
      if (head_job.is_pal) begin
         kind_in   = c2p_pkg::KIND_PALETTE;
         data_in   = head_job.pal_word;
         plane_in  = '0;
         last_in   = 1'b1;
         final_res = 1'b1;
      end else if (has_err && (step_ff == 3'd0)) begin
         kind_in   = c2p_pkg::KIND_ERROR;
         data_in   = '0;
         plane_in  = '0;
         last_in   = 1'b1;
         err_in    = head_job.err;
         final_res = !head_job.close;
      end
   end

   // step counter and queue pop
   always_comb begin
      pop      = load && final_res;
      step_in  = step_ff;
      valid_in = valid_ff && !rsp_chan.ready;
      if (load) begin
         valid_in = 1'b1;
         step_in  = final_res ? 3'd0 : step_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   // output payload register
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= kind_in;
         data_ff  <= data_in;
         plane_ff <= plane_in;
         last_ff  <= last_in;
         count_ff <= count_in;
         err_ff   <= err_in;
      end
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.kind         = kind_ff;
   assign rsp_chan.data_word    = data_ff;
   assign rsp_chan.plane_number = plane_ff;
   assign rsp_chan.group_last   = last_ff;
   assign rsp_chan.color_count  = count_ff;
   assign rsp_chan.error_code   = err_ff;

endmodule

`default_nettype wire

// ----- src/sprite_chunky_to_planar_packer.sv -----
// Takes one transaction per cycle while the four-job queue has room; a pixel is
// classified in the cycle it is accepted (parallel match against the learned
// colors, append of a new color, plane shift). Results leave one per cycle from
// the output register while the response channel is ready, so a pixel that
// closes a group yields an optional error report, then 2 or 4 plane words, and
// a full group of 16 pixels drains as 2 or 4 plane words. No clearing pass
// follows reset; register writes take effect in the next cycle.
// ----------------------------------------------------------------------------
// sprite_chunky_to_planar_packer
// Top level: register file, front classifier, job queue and result back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_chunky_to_planar_packer #(
   parameter int PALETTE_ENTRIES = 16,
   parameter int MAX_ROW_WIDTH   = 128
) (
   input  wire logic clock,
   input  wire logic reset,
   c2p_req_if.sink   req_chan,
   c2p_rsp_if.source rsp_chan,
   c2p_csr_if.sink   csr_chan
);

   c2p_pkg::cfg_type      cfg_ff, cfg_in;
   c2p_pkg::job_type      push_job;
   c2p_pkg::job_type      head_job;
   c2p_pkg::q_status_type q_status;
   logic                  push;
   logic                  pop;

   // register writes
   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            c2p_pkg::REG_ROW_WIDTH:   cfg_in.row_width   = csr_chan.data;
            c2p_pkg::REG_ATTACH_MODE: cfg_in.attach_mode = csr_chan.data[0];
            c2p_pkg::REG_INDEX_INPUT: cfg_in.index_input = csr_chan.data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_width   <= c2p_pkg::ROW_WIDTH_RESET;
         cfg_ff.attach_mode <= 1'b0;
         cfg_ff.index_input <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   c2p_front #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES),
      .MAX_ROW_WIDTH   (MAX_ROW_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .cfg      (cfg_ff),
      .q_status (q_status),
      .push     (push),
      .push_job (push_job)
   );

   c2p_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_status (q_status)
   );

   c2p_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_job (head_job),
      .q_status (q_status),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

`ifndef ASSERT_OFF
   // queue never written while full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("job pushed into a full queue");

   // queue never popped while empty
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("job popped from an empty queue");

   // an error report is a single last word with no data
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.kind == c2p_pkg::KIND_ERROR)) |->
      (rsp_chan.group_last && (rsp_chan.data_word == 16'h0000) &&
       (rsp_chan.error_code != c2p_pkg::ERR_NONE)))
      else $error("malformed error report");

   // nothing offered right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("response valid after reset");
`endif

endmodule

`default_nettype wire
